FILE: rtl/core/mccd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mccd_pkg;

    localparam int ID_W      = 11;
    localparam int TICK_W    = 24;
    localparam int MODE_W    = 4;
    localparam int CODE_W    = 2;
    localparam int BYTE_W    = 8;
    localparam int HALF_W    = 16;
    localparam int WORD_W    = 32;
    localparam int CFG_IDX_W = 2;

    // dividend is speed * 2^32, retired two quotient bits per cycle
    localparam int DIVIDEND_W   = HALF_W + WORD_W;
    localparam int RADIX_BITS   = 2;
    localparam int DIV_CYCLES   = DIVIDEND_W / RADIX_BITS;

    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_NODE_ID   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHARED_ID = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_RATE = 2'd2;

    localparam logic [ID_W-1:0]   NODE_ID_RST   = 11'd1;
    localparam logic [ID_W-1:0]   SHARED_ID_RST = 11'd0;
    localparam logic [TICK_W-1:0] TICK_RATE_RST = 24'd20000;

    localparam logic [BYTE_W-1:0] CMD_STOP       = 8'd1;
    localparam logic [BYTE_W-1:0] CMD_POWER_ON   = 8'd2;
    localparam logic [BYTE_W-1:0] CMD_STEP_PLUS  = 8'd3;
    localparam logic [BYTE_W-1:0] CMD_STEP_MINUS = 8'd4;
    localparam logic [BYTE_W-1:0] CMD_RECIPROC   = 8'd5;
    localparam logic [BYTE_W-1:0] CMD_ABS_MOVE   = 8'd6;
    localparam logic [BYTE_W-1:0] CMD_SYNC_LOAD  = 8'd7;
    localparam logic [BYTE_W-1:0] CMD_SYNC_FIRE  = 8'd8;
    localparam logic [BYTE_W-1:0] CMD_VELOCITY   = 8'd9;

    localparam logic [MODE_W-1:0] MODE_IDLE     = 4'd0;
    localparam logic [MODE_W-1:0] MODE_READY    = 4'd1;
    localparam logic [MODE_W-1:0] MODE_POSITION = 4'd2;
    localparam logic [MODE_W-1:0] MODE_REPEAT   = 4'd3;
    localparam logic [MODE_W-1:0] MODE_SYNC     = 4'd4;
    localparam logic [MODE_W-1:0] MODE_VELOCITY = 4'd5;
    localparam logic [MODE_W-1:0] MODE_OVER_HVV = 4'd6;
    localparam logic [MODE_W-1:0] MODE_OVER_HVI = 4'd7;
    localparam logic [MODE_W-1:0] MODE_OVER_DCI = 4'd8;
    localparam logic [MODE_W-1:0] MODE_ERROR    = 4'd9;

    localparam logic [CODE_W-1:0] PWR_NONE = 2'd0;
    localparam logic [CODE_W-1:0] PWR_OFF  = 2'd1;
    localparam logic [CODE_W-1:0] PWR_ON   = 2'd2;

    localparam logic [CODE_W-1:0] INC_NONE     = 2'd0;
    localparam logic [CODE_W-1:0] INC_POSITION = 2'd1;
    localparam logic [CODE_W-1:0] INC_VELOCITY = 2'd2;

    localparam logic [CODE_W-1:0] REPLY_NONE    = 2'd0;
    localparam logic [CODE_W-1:0] REPLY_OK      = 2'd1;
    localparam logic [CODE_W-1:0] REPLY_UNKNOWN = 2'd2;

    typedef struct packed {
        logic [ID_W-1:0]   node_id;
        logic [ID_W-1:0]   shared_id;
        logic [TICK_W-1:0] tick_rate_hz;
    } cfg_t;

    // decoded frame, everything but the phase increment
    typedef struct packed {
        logic [MODE_W-1:0]        next_mode;
        logic [CODE_W-1:0]        power_action;
        logic [CODE_W-1:0]        increment_kind;
        logic [HALF_W-1:0]        div_speed;
        logic                     target_write;
        logic signed [WORD_W-1:0] target_position;
        logic                     repeat_write;
        logic [HALF_W-1:0]        repeat_pos_a;
        logic [HALF_W-1:0]        repeat_pos_b;
        logic [BYTE_W-1:0]        repeat_count;
        logic [CODE_W-1:0]        reply;
        logic [BYTE_W-1:0]        reply_command;
    } job_t;

endpackage

`default_nettype wire

FILE: rtl/core/mccd_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface mccd_frame_if;
    logic                                 valid;
    logic                                 ready;
    logic [mccd_pkg::ID_W-1:0]            frame_id;
    logic [mccd_pkg::BYTE_W-1:0]          byte0;
    logic [mccd_pkg::BYTE_W-1:0]          byte1;
    logic [mccd_pkg::BYTE_W-1:0]          byte2;
    logic [mccd_pkg::BYTE_W-1:0]          byte3;
    logic [mccd_pkg::BYTE_W-1:0]          byte4;
    logic [mccd_pkg::BYTE_W-1:0]          byte5;
    logic [mccd_pkg::BYTE_W-1:0]          byte6;
    logic [mccd_pkg::BYTE_W-1:0]          byte7;
    logic [mccd_pkg::MODE_W-1:0]          current_mode;
    logic signed [mccd_pkg::WORD_W-1:0]   current_step;

    modport source (output valid, frame_id, byte0, byte1, byte2, byte3, byte4, byte5,
                    byte6, byte7, current_mode, current_step, input ready);
    modport sink   (input valid, frame_id, byte0, byte1, byte2, byte3, byte4, byte5,
                    byte6, byte7, current_mode, current_step, output ready);
endinterface

interface mccd_result_if;
    logic                                 valid;
    logic                                 ready;
    logic [mccd_pkg::MODE_W-1:0]          next_mode;
    logic [mccd_pkg::CODE_W-1:0]          power_action;
    logic [mccd_pkg::CODE_W-1:0]          increment_kind;
    logic [mccd_pkg::WORD_W-1:0]          phase_increment;
    logic                                 target_write;
    logic signed [mccd_pkg::WORD_W-1:0]   target_position;
    logic                                 repeat_write;
    logic [mccd_pkg::HALF_W-1:0]          repeat_pos_a;
    logic [mccd_pkg::HALF_W-1:0]          repeat_pos_b;
    logic [mccd_pkg::BYTE_W-1:0]          repeat_count;
    logic [mccd_pkg::CODE_W-1:0]          reply;
    logic [mccd_pkg::BYTE_W-1:0]          reply_command;

    modport source (output valid, next_mode, power_action, increment_kind, phase_increment,
                    target_write, target_position, repeat_write, repeat_pos_a,
                    repeat_pos_b, repeat_count, reply, reply_command, input ready);
    modport sink   (input valid, next_mode, power_action, increment_kind, phase_increment,
                    target_write, target_position, repeat_write, repeat_pos_a,
                    repeat_pos_b, repeat_count, reply, reply_command, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/mccd_front.sv
`timescale 1ns / 1ps
`default_nettype none

module mccd_front
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    mccd_frame_if.sink          frame_ch,
    input  wire mccd_pkg::cfg_t cfg,
    output logic                push_valid,
    input  wire logic           push_ready,
    output mccd_pkg::job_t      push_job
);

    logic [mccd_pkg::HALF_W-1:0] sync_speed_reg;
    logic [mccd_pkg::HALF_W-1:0] sync_speed_next;
    logic [mccd_pkg::HALF_W-1:0] sync_pos_reg;
    logic [mccd_pkg::HALF_W-1:0] sync_pos_next;

    logic                        accept;

    assign frame_ch.ready = push_ready;
    assign push_valid     = frame_ch.valid;
    assign accept         = frame_ch.valid && push_ready;

    always_comb
    begin
        logic [mccd_pkg::HALF_W-1:0] speed;
        logic [mccd_pkg::HALF_W-1:0] pos_a;
        logic [mccd_pkg::HALF_W-1:0] pos_b;
        logic [mccd_pkg::MODE_W-1:0] mode;
        logic                        to_node;
        logic                        to_bcast;
        logic                        ok;

        speed    = {frame_ch.byte2, frame_ch.byte1};
        pos_a    = {frame_ch.byte4, frame_ch.byte3};
        pos_b    = {frame_ch.byte6, frame_ch.byte5};
        mode     = frame_ch.current_mode;
        to_node  = (frame_ch.frame_id == cfg.node_id);
        to_bcast = (frame_ch.frame_id == cfg.shared_id);
        ok       = 1'b1;

        push_job           = '0;
        push_job.div_speed = speed;
        sync_speed_next    = sync_speed_reg;
        sync_pos_next      = sync_pos_reg;

        if (to_node || to_bcast)
        begin
            unique case (frame_ch.byte0)
                mccd_pkg::CMD_STOP:
                begin
                    push_job.power_action = mccd_pkg::PWR_OFF;
                    if (mode < mccd_pkg::MODE_OVER_HVV || mode > mccd_pkg::MODE_ERROR)
                        mode = mccd_pkg::MODE_IDLE;
                end
                mccd_pkg::CMD_POWER_ON:
                begin
                    push_job.power_action = mccd_pkg::PWR_ON;
                    mode                  = mccd_pkg::MODE_READY;
                end
                mccd_pkg::CMD_STEP_PLUS:
                begin
                    push_job.increment_kind  = mccd_pkg::INC_POSITION;
                    push_job.target_write    = 1'b1;
                    push_job.target_position = frame_ch.current_step + 32'sd1;
                    mode                     = mccd_pkg::MODE_POSITION;
                end
                mccd_pkg::CMD_STEP_MINUS:
                begin
                    push_job.increment_kind  = mccd_pkg::INC_POSITION;
                    push_job.target_write    = 1'b1;
                    push_job.target_position = frame_ch.current_step - 32'sd1;
                    mode                     = mccd_pkg::MODE_POSITION;
                end
                mccd_pkg::CMD_RECIPROC:
                begin
                    push_job.increment_kind = mccd_pkg::INC_POSITION;
                    push_job.repeat_write   = 1'b1;
                    push_job.repeat_pos_a   = pos_a;
                    push_job.repeat_pos_b   = pos_b;
                    push_job.repeat_count   = frame_ch.byte7;
                    mode                    = mccd_pkg::MODE_REPEAT;
                end
                mccd_pkg::CMD_ABS_MOVE:
                begin
                    push_job.increment_kind  = mccd_pkg::INC_POSITION;
                    push_job.target_write    = 1'b1;
                    push_job.target_position = {{mccd_pkg::HALF_W{1'b0}}, pos_a};
                    mode                     = mccd_pkg::MODE_POSITION;
                end
                mccd_pkg::CMD_SYNC_LOAD:
                begin
                    // fault modes other than the generic error block the load
                    if (to_node && mode != mccd_pkg::MODE_OVER_HVV
                        && mode != mccd_pkg::MODE_OVER_HVI
                        && mode != mccd_pkg::MODE_OVER_DCI)
                    begin
                        mode            = mccd_pkg::MODE_SYNC;
                        sync_speed_next = speed;
                        sync_pos_next   = pos_a;
                    end
                end
                mccd_pkg::CMD_SYNC_FIRE:
                begin
                    if (to_bcast && mode == mccd_pkg::MODE_SYNC)
                    begin
                        push_job.increment_kind  = mccd_pkg::INC_POSITION;
                        push_job.div_speed       = sync_speed_reg;
                        push_job.target_write    = 1'b1;
                        push_job.target_position = {{mccd_pkg::HALF_W{1'b0}}, sync_pos_reg};
                    end
                end
                mccd_pkg::CMD_VELOCITY:
                begin
                    push_job.increment_kind = mccd_pkg::INC_VELOCITY;
                    mode                    = mccd_pkg::MODE_VELOCITY;
                end
                default:
                begin
                    ok = 1'b0;
                end
            endcase

            if (!to_bcast)
            begin
                push_job.reply         = ok ? mccd_pkg::REPLY_OK : mccd_pkg::REPLY_UNKNOWN;
                push_job.reply_command = frame_ch.byte0;
            end
        end

        push_job.next_mode = mode;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_speed_reg <= '0;
            sync_pos_reg   <= '0;
        end
        else if (accept)
        begin
            sync_speed_reg <= sync_speed_next;
            sync_pos_reg   <= sync_pos_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/mccd_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module mccd_queue
#(
    parameter int DEPTH = mccd_pkg::QUEUE_DEPTH_DEF
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push_valid,
    output logic                push_ready,
    input  wire mccd_pkg::job_t push_job,
    output logic                pop_valid,
    input  wire logic           pop_ready,
    output mccd_pkg::job_t      pop_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mccd_pkg::job_t   mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    logic push;
    logic pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = mem[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] ptr);
        bump = (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
    endfunction

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= bump(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= bump(rd_ptr_reg);
            if (push && !pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/mccd_back.sv
`timescale 1ns / 1ps
`default_nettype none

module mccd_back
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [mccd_pkg::TICK_W-1:0]  tick_rate_hz,
    input  wire logic                         pop_valid,
    output logic                              pop_ready,
    input  wire mccd_pkg::job_t               pop_job,
    mccd_result_if.source                     result_ch
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    localparam int CNT_W = $clog2(mccd_pkg::DIV_CYCLES + 1);
    localparam int REM_W = mccd_pkg::TICK_W;

    logic [1:0]                  state_reg;
    logic [1:0]                  state_next;
    logic [CNT_W-1:0]            cnt_reg;
    logic [CNT_W-1:0]            cnt_next;
    logic [REM_W-1:0]            rem_reg;
    logic [REM_W-1:0]            rem_next;
    logic [mccd_pkg::HALF_W-1:0] num_reg;
    logic [mccd_pkg::HALF_W-1:0] num_next;
    logic [mccd_pkg::WORD_W-1:0] quo_reg;
    logic [mccd_pkg::WORD_W-1:0] quo_next;
    mccd_pkg::job_t              res_reg;
    mccd_pkg::job_t              res_next;

    logic                        pop;

    // one restoring step: {quotient bit, new remainder}
    // a zero divisor gives all-ones, as wanted
    function automatic logic [REM_W:0] div_step(input logic [REM_W-1:0] rem,
                                                input logic             nb,
                                                input logic [REM_W-1:0] d);
        logic [REM_W:0] trial;
        logic [REM_W:0] diff;
        trial = {rem, nb};
        diff  = trial - {1'b0, d};
        if (trial >= {1'b0, d})
            div_step = {1'b1, diff[REM_W-1:0]};
        else
            div_step = {1'b0, trial[REM_W-1:0]};
    endfunction

    assign pop_ready = (state_reg == ST_IDLE) || (state_reg == ST_HOLD && result_ch.ready);
    assign pop       = pop_valid && pop_ready;

    always_comb
    begin
        logic [REM_W:0] s1;
        logic [REM_W:0] s2;

        s1 = div_step(rem_reg, num_reg[mccd_pkg::HALF_W-1], tick_rate_hz);
        s2 = div_step(s1[REM_W-1:0], num_reg[mccd_pkg::HALF_W-2], tick_rate_hz);

        state_next = state_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        num_next   = num_reg;
        quo_next   = quo_reg;
        res_next   = res_reg;

        unique case (state_reg)
            ST_IDLE, ST_HOLD:
            begin
                if (pop)
                begin
                    res_next = pop_job;
                    quo_next = '0;
                    if (pop_job.increment_kind != mccd_pkg::INC_NONE)
                    begin
                        rem_next   = '0;
                        num_next   = pop_job.div_speed;
                        cnt_next   = CNT_W'(mccd_pkg::DIV_CYCLES);
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        state_next = ST_HOLD;
                    end
                end
                else if (state_reg == ST_HOLD && result_ch.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                rem_next = s2[REM_W-1:0];
                num_next = {num_reg[mccd_pkg::HALF_W-3:0], 2'b00};
                // upper quotient bits fall off the top: only the low word is kept
                quo_next = {quo_reg[mccd_pkg::WORD_W-3:0], s1[REM_W], s2[REM_W]};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                    state_next = ST_HOLD;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        num_reg <= num_next;
        quo_reg <= quo_next;
        res_reg <= res_next;
    end

    assign result_ch.valid           = (state_reg == ST_HOLD);
    assign result_ch.next_mode       = res_reg.next_mode;
    assign result_ch.power_action    = res_reg.power_action;
    assign result_ch.increment_kind  = res_reg.increment_kind;
    assign result_ch.phase_increment = quo_reg;
    assign result_ch.target_write    = res_reg.target_write;
    assign result_ch.target_position = res_reg.target_position;
    assign result_ch.repeat_write    = res_reg.repeat_write;
    assign result_ch.repeat_pos_a    = res_reg.repeat_pos_a;
    assign result_ch.repeat_pos_b    = res_reg.repeat_pos_b;
    assign result_ch.repeat_count    = res_reg.repeat_count;
    assign result_ch.reply           = res_reg.reply;
    assign result_ch.reply_command   = res_reg.reply_command;

`ifndef SYNTHESIS
    a_no_inc_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_HOLD && res_reg.increment_kind == mccd_pkg::INC_NONE)
        |-> (quo_reg == '0))
        else $error("phase increment not zero for a beat without increment");

    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && pop_job.increment_kind != mccd_pkg::INC_NONE)
        |=> (state_reg == ST_DIV && !result_ch.valid))
        else $error("divide not started for a job with an increment");

    a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && cnt_reg == CNT_W'(1)) |=> (state_reg == ST_HOLD))
        else $error("divide did not finish after its last step");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (cnt_reg != '0))
        else $error("divide step counter ran out while dividing");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/motor_can_command_decoder.sv
`timescale 1ns / 1ps
`default_nettype none

// Path: a frame beat is registered in the queue, then in the back end's result register;
// a job with a phase increment first runs a radix-4 restoring divide of speed * 2^32 by
// the tick rate. Throughput: one frame per cycle without an increment while the result
// channel is ready; the back end takes no new job while dividing. A QUEUE_DEPTH-entry
// queue (2 by default) decouples decode from divide. Reset: asynchronous, active low;
// registers to defaults, sync state cleared, queue and divider emptied. No clearing pass.
module motor_can_command_decoder
#(
    parameter int QUEUE_DEPTH = mccd_pkg::QUEUE_DEPTH_DEF
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [mccd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [mccd_pkg::TICK_W-1:0]     cfg_data,
    mccd_frame_if.sink                           frame_ch,
    mccd_result_if.source                        result_ch
);

    mccd_pkg::cfg_t cfg_reg;

    logic           push_valid;
    logic           push_ready;
    mccd_pkg::job_t push_job;
    logic           pop_valid;
    logic           pop_ready;
    mccd_pkg::job_t pop_job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.node_id      <= mccd_pkg::NODE_ID_RST;
            cfg_reg.shared_id    <= mccd_pkg::SHARED_ID_RST;
            cfg_reg.tick_rate_hz <= mccd_pkg::TICK_RATE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mccd_pkg::CFG_NODE_ID:
                    cfg_reg.node_id <= cfg_data[mccd_pkg::ID_W-1:0];
                mccd_pkg::CFG_SHARED_ID:
                    cfg_reg.shared_id <= cfg_data[mccd_pkg::ID_W-1:0];
                mccd_pkg::CFG_TICK_RATE:
                    cfg_reg.tick_rate_hz <= cfg_data;
                default:
                begin
                    // unmapped index, write dropped
                end
            endcase
        end
    end

    mccd_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .frame_ch   (frame_ch),
        .cfg        (cfg_reg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    mccd_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    mccd_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick_rate_hz (cfg_reg.tick_rate_hz),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_job      (pop_job),
        .result_ch    (result_ch)
    );

endmodule

`default_nettype wire
